/* rtl/core/cst_pkg.sv */
// Package for the C subset token scanner: token kind codes, scan modes,
// keyword tables, state and result types, and character class functions.
// Depends on nothing.
package cst_pkg;

   localparam int POS_BITS_DEFAULT = 16;
   localparam int NUM_KW = 5;
   localparam int MAX_RESULTS = 3;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER
   } mode_type;

   localparam logic [3:0] KIND_KEYWORD = 4'd0;
   localparam logic [3:0] KIND_IDENT   = 4'd1;
   localparam logic [3:0] KIND_NUMBER  = 4'd2;
   localparam logic [3:0] KIND_ASSIGN  = 4'd3;
   localparam logic [3:0] KIND_PLUS    = 4'd4;
   localparam logic [3:0] KIND_MINUS   = 4'd5;
   localparam logic [3:0] KIND_STAR    = 4'd6;
   localparam logic [3:0] KIND_SLASH   = 4'd7;
   localparam logic [3:0] KIND_SEMI    = 4'd8;
   localparam logic [3:0] KIND_LPAREN  = 4'd9;
   localparam logic [3:0] KIND_RPAREN  = 4'd10;
   localparam logic [3:0] KIND_LBRACE  = 4'd11;
   localparam logic [3:0] KIND_RBRACE  = 4'd12;
   localparam logic [3:0] KIND_UNKNOWN = 4'd13;
   localparam logic [3:0] KIND_EOF     = 4'd14;

   localparam logic [4:0]  ALL_CANDIDATES = 5'b11111;
   localparam logic [15:0] LEN_MAX = 16'hFFFF;

   // Keyword spellings in order int, float, double, char, return.
   localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
      '{"d", "o", "u", "b", "l", "e", 8'h00, 8'h00},
      '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
   };
   localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd5, 3'd6, 3'd4, 3'd6};

   typedef struct packed {
      mode_type    mode;
      logic [4:0]  cands;
      logic [15:0] len;
   } scan_state_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [2:0]  kid;
      logic [15:0] start;
      logic [15:0] len;
      logic        last;
   } result_type;

   function automatic logic is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
   endfunction

   function automatic logic [3:0] single_kind(logic [7:0] c);
      logic [3:0] k;
      case (c)
         "=": k = KIND_ASSIGN;
         "+": k = KIND_PLUS;
         "-": k = KIND_MINUS;
         "*": k = KIND_STAR;
         "/": k = KIND_SLASH;
         ";": k = KIND_SEMI;
         "(": k = KIND_LPAREN;
         ")": k = KIND_RPAREN;
         "{": k = KIND_LBRACE;
         "}": k = KIND_RBRACE;
         default: k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   // A keyword stays a candidate only while the byte at this offset matches.
   function automatic logic [4:0] filter_candidates(logic [4:0] cands, logic [15:0] len,
                                                    logic [7:0] c);
      logic [4:0] m;
      m = cands;
      for (int k = 0; k < NUM_KW; k++) begin
         if (!(len < 16'(KW_LEN[k]) && KW_TEXT[k][len[2:0]] == c)) begin
            m[k] = 1'b0;
         end
      end
      return m;
   endfunction

endpackage

/* rtl/core/cst_step.sv */
// Combinational step of the token scanner: from the current scan state and
// one input item, the next state and up to three result items.
// Depends on cst_pkg.
module cst_step #(
   parameter int POS_BITS = cst_pkg::POS_BITS_DEFAULT
) (
   input  logic [7:0]                     ch,
   input  logic                           has_char,
   input  logic                           end_of_source,
   input  cst_pkg::scan_state_type        state_cur,
   input  logic [POS_BITS-1:0]            start_cur,
   input  logic [POS_BITS-1:0]            pos_cur,
   output cst_pkg::scan_state_type        state_nxt,
   output logic [POS_BITS-1:0]            start_nxt,
   output logic [POS_BITS-1:0]            pos_nxt,
   output cst_pkg::result_type [2:0]      results,
   output logic [1:0]                     count
);

   localparam int EXT_BITS = (POS_BITS > 16) ? POS_BITS : 16;

   function automatic logic [15:0] clip_pos(logic [POS_BITS-1:0] p);
      logic [EXT_BITS-1:0] e;
      e = EXT_BITS'(p);
      return (e > EXT_BITS'(cst_pkg::LEN_MAX)) ? cst_pkg::LEN_MAX : e[15:0];
   endfunction

   function automatic cst_pkg::result_type close_token(cst_pkg::scan_state_type s,
                                                       logic [POS_BITS-1:0] start);
      cst_pkg::result_type r;
      r.kind  = (s.mode == cst_pkg::MODE_IDENT) ? cst_pkg::KIND_IDENT
                                                : cst_pkg::KIND_NUMBER;
      r.kid   = 3'd0;
      if (s.mode == cst_pkg::MODE_IDENT) begin
         for (int k = 0; k < cst_pkg::NUM_KW; k++) begin
            if (s.cands[k] && s.len == 16'(cst_pkg::KW_LEN[k])) begin
               r.kind = cst_pkg::KIND_KEYWORD;
               r.kid  = 3'(k);
            end
         end
      end
      r.start = clip_pos(start);
      r.len   = s.len;
      r.last  = 1'b0;
      return r;
   endfunction

   logic letter;
   logic digit;
   logic space;

   assign letter = cst_pkg::is_letter(ch);
   assign digit  = cst_pkg::is_digit(ch);
   assign space  = cst_pkg::is_space(ch);

   always_comb begin
      cst_pkg::scan_state_type   st;
      cst_pkg::result_type [2:0] res;
      logic [POS_BITS-1:0]       start;
      logic [POS_BITS-1:0]       pos;
      logic [1:0]                n;

      st    = state_cur;
      start = start_cur;
      pos   = pos_cur;
      res   = '0;
      n     = 2'd0;

      if (has_char) begin
         if (st.mode == cst_pkg::MODE_IDENT && (letter || digit)) begin
            st.cands = cst_pkg::filter_candidates(st.cands, st.len, ch);
            if (st.len != cst_pkg::LEN_MAX) begin
               st.len = st.len + 16'd1;
            end
         end else if (st.mode == cst_pkg::MODE_NUMBER && digit) begin
            if (st.len != cst_pkg::LEN_MAX) begin
               st.len = st.len + 16'd1;
            end
         end else begin
            if (st.mode != cst_pkg::MODE_IDLE) begin
               res[n]  = close_token(st, start);
               n       = n + 2'd1;
               st.mode = cst_pkg::MODE_IDLE;
            end
            if (letter || digit) begin
               st.mode  = letter ? cst_pkg::MODE_IDENT : cst_pkg::MODE_NUMBER;
               start    = pos;
               st.cands = letter ? cst_pkg::filter_candidates(cst_pkg::ALL_CANDIDATES,
                                                              16'd0, ch)
                                 : cst_pkg::ALL_CANDIDATES;
               st.len   = 16'd1;
            end else if (!space) begin
               res[n].kind  = cst_pkg::single_kind(ch);
               res[n].kid   = 3'd0;
               res[n].start = clip_pos(pos);
               res[n].len   = 16'd1;
               res[n].last  = 1'b0;
               n            = n + 2'd1;
            end
         end
         if (pos != {POS_BITS{1'b1}}) begin
            pos = pos + POS_BITS'(1);
         end
      end

      if (end_of_source) begin
         if (st.mode != cst_pkg::MODE_IDLE) begin
            res[n] = close_token(st, start);
            n      = n + 2'd1;
         end
         res[n].kind  = cst_pkg::KIND_EOF;
         res[n].kid   = 3'd0;
         res[n].start = clip_pos(pos);
         res[n].len   = 16'd0;
         res[n].last  = 1'b0;
         n            = n + 2'd1;
         st.mode      = cst_pkg::MODE_IDLE;
         st.cands     = cst_pkg::ALL_CANDIDATES;
         st.len       = 16'd0;
         start        = '0;
         pos          = '0;
      end

      if (n != 2'd0) begin
         res[n - 2'd1].last = 1'b1;
      end

      state_nxt = st;
      start_nxt = start;
      pos_nxt   = pos;
      results   = res;
      count     = n;
   end

endmodule

/* rtl/core/c_subset_token_scanner.sv */
// Token scanner for a small C subset: scan state registers and a three-entry
// result buffer around the combinational step.
// Depends on cst_pkg and cst_step.
//
// Usage: the req channel carries one item per source byte (req_ch with
// req_has_char set); req_end_of_source marks the final item and may come
// with or without a byte. Each accepted item gives zero to three result
// items on the rsp channel, in source order, and the last of them carries
// rsp_last_of_run. The end mark closes any open token, gives an eof item
// and returns the scanner to offset 0 for the next source.
// Results of an item appear in the cycle after it is accepted, from the result buffer.
// Throughput: one item per cycle while each item gives at most one result and
// the receiver does not stall; an item that gives more results holds the req side
// while the result buffer drains, one entry per cycle that the receiver does not
// stall. The input is taken when the buffer is empty or is giving up its last entry
// in the same cycle. When the receiver stalls, the head result holds and req_stall
// rises once the buffer cannot be emptied. Reset is synchronous: it empties the buffer
// and returns the scan state to no open token at offset 0.
module c_subset_token_scanner #(
   parameter int POS_BITS = cst_pkg::POS_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_has_char,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_token_kind,
   output logic [2:0]  rsp_keyword_id,
   output logic [15:0] rsp_start_pos,
   output logic [15:0] rsp_token_len,
   output logic        rsp_last_of_run
);

   cst_pkg::scan_state_type   state_ff, state_in, step_state;
   logic [POS_BITS-1:0]       start_ff, start_in, step_start;
   logic [POS_BITS-1:0]       pos_ff, pos_in, step_pos;
   cst_pkg::result_type [2:0] slot_ff, slot_in, step_results;
   logic [1:0]                count_ff, count_in, step_count;
   logic                      accept;
   logic                      pop;

   cst_step #(
      .POS_BITS(POS_BITS)
   ) u_step (
      .ch            (req_ch),
      .has_char      (req_has_char),
      .end_of_source (req_end_of_source),
      .state_cur     (state_ff),
      .start_cur     (start_ff),
      .pos_cur       (pos_ff),
      .state_nxt     (step_state),
      .start_nxt     (step_start),
      .pos_nxt       (step_pos),
      .results       (step_results),
      .count         (step_count)
   );

   assign pop       = (count_ff != 2'd0) && !rsp_stall;
   assign req_stall = !((count_ff == 2'd0) || (count_ff == 2'd1 && pop));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      start_in = start_ff;
      pos_in   = pos_ff;
      slot_in  = slot_ff;
      count_in = count_ff;
      if (accept) begin
         state_in = step_state;
         start_in = step_start;
         pos_in   = step_pos;
         slot_in  = step_results;
         count_in = step_count;
      end else if (pop) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         count_in   = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode  <= cst_pkg::MODE_IDLE;
         state_ff.cands <= cst_pkg::ALL_CANDIDATES;
         state_ff.len   <= 16'd0;
         start_ff       <= '0;
         pos_ff         <= '0;
         count_ff       <= 2'd0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign rsp_valid       = count_ff != 2'd0;
   assign rsp_token_kind  = slot_ff[0].kind;
   assign rsp_keyword_id  = slot_ff[0].kid;
   assign rsp_start_pos   = slot_ff[0].start;
   assign rsp_token_len   = slot_ff[0].len;
   assign rsp_last_of_run = slot_ff[0].last;

`ifndef SYNTHESIS
   a_fill_count : assert property (@(posedge clock) disable iff (reset)
      accept |=> count_ff == $past(step_count))
      else $error("result buffer count does not match the accepted item");

   a_last_at_tail : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_run |-> count_ff == 2'd1)
      else $error("last result of an item is not at the tail of the buffer");

   a_eof_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == cst_pkg::KIND_EOF |-> rsp_last_of_run)
      else $error("eof result is not the last result of its item");

   a_restart : assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_source |=> pos_ff == '0 && state_ff.mode == cst_pkg::MODE_IDLE)
      else $error("scanner did not restart after the end of the source");
`endif

endmodule

/* tb/token_stream_checker.sv */
// Checker for the C subset token scanner: watches both channels, predicts the
// token items of each accepted source item and compares them in order.
// Depends on cst_pkg for the kind codes, scan modes and the result type.
module token_stream_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_has_char,
   input  logic        req_end_of_source,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_token_kind,
   input  logic [2:0]  rsp_keyword_id,
   input  logic [15:0] rsp_start_pos,
   input  logic [15:0] rsp_token_len,
   input  logic        rsp_last_of_run,
   output int          fail_count,
   output int          outstanding
);

   string kw_words [cst_pkg::NUM_KW] = '{"int", "float", "double", "char", "return"};

   cst_pkg::mode_type   cur_mode;
   logic [15:0]         tok_start;
   logic [15:0]         tok_len;
   logic [15:0]         src_pos;
   logic [4:0]          kw_live;
   cst_pkg::result_type pending_tokens [$];
   int                  mismatches = 0;
   int                  queued = 0;

   assign fail_count  = mismatches;
   assign outstanding = queued;

   task automatic reset_scan();
      cur_mode  = cst_pkg::MODE_IDLE;
      tok_start = '0;
      tok_len   = '0;
      src_pos   = '0;
      kw_live   = cst_pkg::ALL_CANDIDATES;
   endtask

   task automatic narrow_keywords(input logic [7:0] c);
      for (int k = 0; k < cst_pkg::NUM_KW; k++) begin
         if (tok_len >= kw_words[k].len() || kw_words[k][tok_len] != c) begin
            kw_live[k] = 1'b0;
         end
      end
   endtask

   task automatic add_token(input logic [3:0] kind, input logic [2:0] kid,
                            input logic [15:0] start, input logic [15:0] len);
      cst_pkg::result_type t;
      t.kind  = kind;
      t.kid   = kid;
      t.start = start;
      t.len   = len;
      t.last  = 1'b0;
      pending_tokens.insert(pending_tokens.size(), t);
   endtask

   task automatic close_open(inout int n);
      logic [3:0] kind;
      logic [2:0] kid;
      if (cur_mode != cst_pkg::MODE_IDLE) begin
         kind = (cur_mode == cst_pkg::MODE_IDENT) ? cst_pkg::KIND_IDENT
                                                  : cst_pkg::KIND_NUMBER;
         kid  = '0;
         if (cur_mode == cst_pkg::MODE_IDENT) begin
            for (int k = 0; k < cst_pkg::NUM_KW; k++) begin
               if (kw_live[k] && tok_len == kw_words[k].len()) begin
                  kind = cst_pkg::KIND_KEYWORD;
                  kid  = 3'(k);
               end
            end
         end
         add_token(kind, kid, tok_start, tok_len);
         cur_mode = cst_pkg::MODE_IDLE;
         n++;
      end
   endtask

   function automatic logic [3:0] operator_kind(input logic [7:0] c);
      case (c)
         "=":     return cst_pkg::KIND_ASSIGN;
         "+":     return cst_pkg::KIND_PLUS;
         "-":     return cst_pkg::KIND_MINUS;
         "*":     return cst_pkg::KIND_STAR;
         "/":     return cst_pkg::KIND_SLASH;
         ";":     return cst_pkg::KIND_SEMI;
         "(":     return cst_pkg::KIND_LPAREN;
         ")":     return cst_pkg::KIND_RPAREN;
         "{":     return cst_pkg::KIND_LBRACE;
         "}":     return cst_pkg::KIND_RBRACE;
         default: return cst_pkg::KIND_UNKNOWN;
      endcase
   endfunction

   task automatic scan_item(input logic [7:0] c, input logic has, input logic eos);
      logic letter;
      logic digit;
      int   n;
      n      = 0;
      letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
      digit  = c >= "0" && c <= "9";
      if (has) begin
         if (cur_mode == cst_pkg::MODE_IDENT && (letter || digit)) begin
            narrow_keywords(c);
            if (tok_len != 16'hFFFF) tok_len++;
         end else if (cur_mode == cst_pkg::MODE_NUMBER && digit) begin
            if (tok_len != 16'hFFFF) tok_len++;
         end else begin
            close_open(n);
            if (letter || digit) begin
               cur_mode  = letter ? cst_pkg::MODE_IDENT : cst_pkg::MODE_NUMBER;
               tok_start = src_pos;
               tok_len   = '0;
               kw_live   = cst_pkg::ALL_CANDIDATES;
               if (letter) narrow_keywords(c);
               tok_len = 16'd1;
            end else if (!(c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D)) begin
               add_token(operator_kind(c), 3'd0, src_pos, 16'd1);
               n++;
            end
         end
         if (src_pos != 16'hFFFF) src_pos++;
      end
      if (eos) begin
         close_open(n);
         add_token(cst_pkg::KIND_EOF, 3'd0, src_pos, 16'd0);
         n++;
         reset_scan();
      end
      if (n > 0) pending_tokens[pending_tokens.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      cst_pkg::result_type got;
      cst_pkg::result_type want;
      if (reset) begin
         reset_scan();
         pending_tokens.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.kind  = rsp_token_kind;
            got.kid   = rsp_keyword_id;
            got.start = rsp_start_pos;
            got.len   = rsp_token_len;
            got.last  = rsp_last_of_run;
            if (pending_tokens.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected item: kind %0d kid %0d start %0d len %0d last %0b",
                           got.kind, got.kid, got.start, got.len, got.last);
               end
            end else begin
               want = pending_tokens.pop_front();
               if (got.kind !== want.kind || got.kid !== want.kid ||
                   got.start !== want.start || got.len !== want.len ||
                   got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("expected kind %0d kid %0d start %0d len %0d last %0b",
                              want.kind, want.kid, want.start, want.len, want.last);
                     $display("got      kind %0d kid %0d start %0d len %0d last %0b",
                              got.kind, got.kid, got.start, got.len, got.last);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            scan_item(req_ch, req_has_char, req_end_of_source);
         end
      end
      queued <= pending_tokens.size();
   end

endmodule

/* tb/tb_top.sv */
// Testbench top for the C subset token scanner: clock, reset, source byte
// stimulus with random gaps and receiver stalls, and the final verdict.
// Depends on c_subset_token_scanner, token_stream_checker and cst_pkg.
module tb_top;

   localparam int RANDOM_ITEMS = 340;
   localparam int HOLD_CYCLES  = 150;
   localparam int CYCLE_LIMIT  = 1_000_000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_ch;
   logic        req_has_char;
   logic        req_end_of_source;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_token_kind;
   logic [2:0]  rsp_keyword_id;
   logic [15:0] rsp_start_pos;
   logic [15:0] rsp_token_len;
   logic        rsp_last_of_run;
   int          fail_count;
   int          outstanding;

   int          items_sent = 0;
   int          hold_asked = 0;
   logic        calm = 1'b0;
   int          cycles = 0;

   string       keyword_texts [5] = '{"int", "float", "double", "char", "return"};
   string       ident_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
   string       ident_tail = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   string       digits     = "0123456789";
   string       operators  = "=+-*/;(){}";
   logic [7:0]  blanks [4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};

   c_subset_token_scanner dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_ch            (req_ch),
      .req_has_char      (req_has_char),
      .req_end_of_source (req_end_of_source),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_keyword_id    (rsp_keyword_id),
      .rsp_start_pos     (rsp_start_pos),
      .rsp_token_len     (rsp_token_len),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   token_stream_checker token_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_ch            (req_ch),
      .req_has_char      (req_has_char),
      .req_end_of_source (req_end_of_source),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_keyword_id    (rsp_keyword_id),
      .rsp_start_pos     (rsp_start_pos),
      .rsp_token_len     (rsp_token_len),
      .rsp_last_of_run   (rsp_last_of_run),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] pick_char(input string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   task automatic send_item(input logic [7:0] c, input logic has, input logic eos);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_ch            <= c;
      req_has_char      <= has;
      req_end_of_source <= eos;
      do @(posedge clock); while (req_stall);
      if (has || eos) items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_item(s[i], 1'b1, 1'b0);
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic send_random_token();
      string word;
      int    r;
      int    shape;
      r = $urandom_range(0, 99);
      if (r < 20) begin
         word  = keyword_texts[$urandom_range(0, 4)];
         shape = $urandom_range(0, 3);
         if (shape == 0) word = word.substr(0, $urandom_range(0, word.len() - 2));
         send_text(word);
         if (shape == 1) send_item(pick_char(ident_tail), 1'b1, 1'b0);
      end else if (r < 40) begin
         send_item(pick_char(ident_head), 1'b1, 1'b0);
         repeat ($urandom_range(0, 7)) send_item(pick_char(ident_tail), 1'b1, 1'b0);
      end else if (r < 55) begin
         repeat ($urandom_range(1, 5)) send_item(pick_char(digits), 1'b1, 1'b0);
      end else if (r < 75) begin
         send_item(pick_char(operators), 1'b1, 1'b0);
      end else if (r < 82) begin
         send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end else if (r < 90) begin
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end else begin
         send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      end
      if ($urandom_range(0, 1)) send_item(blanks[$urandom_range(0, 3)], 1'b1, 1'b0);
   endtask

   // Receiver: random stalls, plus one long hold-off when the sender asks for it.
   initial begin
      int stall_len;
      int holds_served;
      rsp_stall    = 1'b0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (hold_asked != holds_served) begin
            holds_served = hold_asked;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            stall_len = pick_gap();
            if (stall_len > 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_len) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   initial begin
      logic held;
      logic drained;
      held              = 1'b0;
      drained           = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_ch            = 8'h00;
      req_has_char      = 1'b0;
      req_end_of_source = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Keyword closed by an operator, a number running into an identifier,
      // all operators, all blanks, unknown bytes at both ends of the range,
      // an empty item, and end marks with and without a byte.
      send_text("int{");
      send_text("7_");
      send_item(8'h09, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_text("=+-*/;()}");
      send_item(8'h0D, 1'b1, 1'b0);
      send_item(8'h0A, 1'b1, 1'b0);
      send_item(8'h20, 1'b1, 1'b0);
      send_item(8'hA5, 1'b0, 1'b0);
      send_text("q");
      send_item("+", 1'b1, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);
      send_text("9");
      send_item(8'h5A, 1'b0, 1'b1);

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (!held && items_sent >= 100) begin
            hold_asked <= hold_asked + 1;
            held = 1'b1;
         end
         if (!drained && items_sent >= 200) begin
            req_valid <= 1'b0;
            wait_drained();
            drained = 1'b1;
         end
         calm <= (items_sent >= 250 && items_sent < 300);
         send_random_token();
      end
      send_item(8'h00, 1'b0, 1'b1);

      req_valid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/cst_pkg.sv
rtl/core/cst_step.sv
rtl/core/c_subset_token_scanner.sv
tb/token_stream_checker.sv
tb/tb_top.sv
